### design/rhct_pkg.sv
package rhct_pkg;

  // number of quotient bits, one divider cell per bit
  localparam int unsigned DivSteps = 8;

  // hue sector offsets
  localparam logic [7:0] HueBaseRed   = 8'd0;
  localparam logic [7:0] HueBaseGreen = 8'd85;
  localparam logic [7:0] HueBaseBlue  = 8'd171;

  // scale factors of the two dividends
  localparam logic [7:0] SatScale = 8'd255;
  localparam logic [5:0] HueScale = 6'd43;

  // register reset values
  localparam logic [7:0] HueLowRst  = 8'd121;
  localparam logic [7:0] HueHighRst = 8'd179;
  localparam logic [7:0] SatLowRst  = 8'd158;
  localparam logic [7:0] SatHighRst = 8'd255;
  localparam logic [7:0] ValLowRst  = 8'd41;
  localparam logic [7:0] ValHighRst = 8'd255;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegHueLow  = 3'd0,
    RegHueHigh = 3'd1,
    RegSatLow  = 3'd2,
    RegSatHigh = 3'd3,
    RegValLow  = 3'd4,
    RegValHigh = 3'd5
  } cfg_reg_e;

  // one restoring divider lane: partial remainder, dividend bits left, divisor, quotient
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] num;
    logic [7:0]  den;
    logic [7:0]  quo;
  } div_lane_t;

  // everything that travels down the row of cells with one pixel
  typedef struct packed {
    div_lane_t  sat;
    div_lane_t  hue;
    logic [7:0] hue_base;
    logic       hue_neg;
    logic       zero_hue;
    logic       zero_sat;
    logic [7:0] val;
  } cell_data_t;

endpackage

### design/rhct_front.sv
module rhct_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [15:0]         pixel_rgb565_i,
  output logic                vld_o,
  output rhct_pkg::cell_data_t data_o
);
  import rhct_pkg::*;

  logic [7:0]  r, g, b;
  logic [7:0]  mx, mn, delta;
  logic [8:0]  diff;
  logic [7:0]  diff_abs;
  logic [15:0] sat_num, hue_num;
  logic [13:0] hue_prod;
  logic [7:0]  base;
  logic        red_max, green_max;

  cell_data_t data_d, data_q;
  logic       vld_q;

  // channel expansion
  assign r = {pixel_rgb565_i[15:11], 3'b000};
  assign g = {pixel_rgb565_i[10:5], 2'b00};
  assign b = {pixel_rgb565_i[4:0], 3'b000};

  // largest channel with ties to red, then green
  assign red_max   = (r >= g) && (r >= b);
  assign green_max = !red_max && (g >= b);

  always_comb begin
    if (red_max) begin
      mx   = r;
      base = HueBaseRed;
      diff = {1'b0, g} - {1'b0, b};
    end else if (green_max) begin
      mx   = g;
      base = HueBaseGreen;
      diff = {1'b0, b} - {1'b0, r};
    end else begin
      mx   = b;
      base = HueBaseBlue;
      diff = {1'b0, r} - {1'b0, g};
    end
  end

  // smallest channel
  always_comb begin
    mn = (r < g) ? r : g;
    if (b < mn) begin
      mn = b;
    end
  end

  assign delta    = mx - mn;
  assign diff_abs = diff[8] ? 8'(-diff) : diff[7:0];

  // dividends: 255 * delta and 43 * |diff|
  assign sat_num  = 16'({delta, 8'h00}) - 16'(delta);
  assign hue_prod = 14'(diff_abs) * 14'(HueScale);
  assign hue_num  = 16'(hue_prod);

  // seed both divider lanes, upper dividend byte as first remainder
  always_comb begin
    data_d.sat.rem  = sat_num[15:8];
    data_d.sat.num  = {sat_num[7:0], 8'h00};
    data_d.sat.den  = mx;
    data_d.sat.quo  = '0;
    data_d.hue.rem  = hue_num[15:8];
    data_d.hue.num  = {hue_num[7:0], 8'h00};
    data_d.hue.den  = delta;
    data_d.hue.quo  = '0;
    data_d.hue_base = base;
    data_d.hue_neg  = diff[8];
    data_d.zero_hue = (mx == 8'd0) || (delta == 8'd0);
    data_d.zero_sat = (mx == 8'd0);
    data_d.val      = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

### design/rhct_div_cell.sv
module rhct_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  rhct_pkg::cell_data_t data_i,
  output logic                vld_o,
  output rhct_pkg::cell_data_t data_o
);
  import rhct_pkg::*;

  cell_data_t data_d, data_q;
  logic       vld_q;

  // one restoring step on a lane: shift in a dividend bit, subtract if it fits
  function automatic div_lane_t div_step(input div_lane_t lane);
    logic [8:0] rem_ext;
    logic [8:0] rem_sub;
    logic       fits;
    div_lane_t  res;
    rem_ext = {lane.rem, lane.num[15]};
    rem_sub = rem_ext - {1'b0, lane.den};
    fits    = rem_ext >= {1'b0, lane.den};
    res.rem = fits ? rem_sub[7:0] : rem_ext[7:0];
    res.num = {lane.num[14:0], 1'b0};
    res.den = lane.den;
    res.quo = {lane.quo[6:0], fits};
    return res;
  endfunction

  always_comb begin
    data_d     = data_i;
    data_d.sat = div_step(data_i.sat);
    data_d.hue = div_step(data_i.hue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

### design/rgb565_hsv_color_threshold.sv
// throughput: one pixel per cycle; a front stage, a row of 8 divider cells
// (one quotient bit each) and an output register
// busy is never raised and the receiver cannot stall: one result beat per pixel
// reset: strobe and pipeline valid bits cleared, bounds return to their defaults
module rgb565_hsv_color_threshold (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] pixel_rgb565_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic        in_range_o,
  output logic [7:0]  hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  brightness_o
);
  import rhct_pkg::*;

  logic       vld_chain [DivSteps+1];
  cell_data_t data_chain[DivSteps+1];

  logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, val_low_q, val_high_q;

  cell_data_t last;
  logic [7:0] hue_d, sat_d;
  logic       in_range_d;

  logic       done_q, in_range_q;
  logic [7:0] hue_q, sat_q, val_q;

  assign busy = 1'b0;

  // bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HueLowRst;
      hue_high_q <= HueHighRst;
      sat_low_q  <= SatLowRst;
      sat_high_q <= SatHighRst;
      val_low_q  <= ValLowRst;
      val_high_q <= ValHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHueLow:  hue_low_q  <= cfg_data_i;
        RegHueHigh: hue_high_q <= cfg_data_i;
        RegSatLow:  sat_low_q  <= cfg_data_i;
        RegSatHigh: sat_high_q <= cfg_data_i;
        RegValLow:  val_low_q  <= cfg_data_i;
        RegValHigh: val_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // channel expansion, max/min and dividend setup
  rhct_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (start && !busy),
    .pixel_rgb565_i (pixel_rgb565_i),
    .vld_o          (vld_chain[0]),
    .data_o         (data_chain[0])
  );

  // row of divider cells
  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    rhct_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_chain[i]),
      .data_i (data_chain[i]),
      .vld_o  (vld_chain[i+1]),
      .data_o (data_chain[i+1])
    );
  end

  assign last = data_chain[DivSteps];

  // hue offset sign, black and grey cases
  always_comb begin
    sat_d = last.zero_sat ? 8'd0 : last.sat.quo;
    if (last.zero_hue || (sat_d == 8'd0)) begin
      hue_d = 8'd0;
    end else if (last.hue_neg) begin
      hue_d = last.hue_base - last.hue.quo;
    end else begin
      hue_d = last.hue_base + last.hue.quo;
    end
    in_range_d = (hue_d >= hue_low_q) && (hue_d <= hue_high_q)
              && (sat_d >= sat_low_q) && (sat_d <= sat_high_q)
              && (last.val >= val_low_q) && (last.val <= val_high_q);
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_chain[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    in_range_q <= in_range_d;
    hue_q      <= hue_d;
    sat_q      <= sat_d;
    val_q      <= last.val;
  end

  assign done_o       = done_q;
  assign in_range_o   = in_range_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

endmodule

### verif/hsv_threshold_checker.sv
`timescale 1ns / 100ps

// watches the pixel and result channels of the hsv threshold block,
// predicts each result beat and compares it field by field
module hsv_threshold_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] pixel_rgb565_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        done_i,
  input  logic        in_range_i,
  input  logic [7:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  output int          pending_o,
  output int          fail_count_o
);
  import rhct_pkg::*;

  localparam int PrintCap = 60;

  typedef struct packed {
    logic       in_range;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_beat_t;

  // local copy of the window bounds
  logic [7:0] hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;

  hsv_beat_t hsv_expected_q[$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // rgb565 to 8-bit hsv, then the window test
  function automatic hsv_beat_t hsv_of_pixel(input logic [15:0] px);
    logic [7:0] r, g, b, mx, mn, dlt;
    int         base, diff, quo, sat_full;
    hsv_beat_t  res;
    r = {px[15:11], 3'b000};
    g = {px[10:5], 2'b00};
    b = {px[4:0], 3'b000};
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    dlt = mx - mn;
    res.val = mx;
    res.hue = '0;
    res.sat = '0;
    if (mx != 0) begin
      sat_full = (int'(SatScale) * int'(dlt)) / int'(mx);
      res.sat = sat_full[7:0];
      // grey pixels keep hue at zero; ties favor red, then green
      if (sat_full != 0 && dlt != 0) begin
        if (mx == r) begin
          base = int'(HueBaseRed);
          diff = int'(g) - int'(b);
        end else if (mx == g) begin
          base = int'(HueBaseGreen);
          diff = int'(b) - int'(r);
        end else begin
          base = int'(HueBaseBlue);
          diff = int'(r) - int'(g);
        end
        // signed division truncates toward zero, sum wraps mod 256
        quo = (int'(HueScale) * diff) / int'(dlt);
        res.hue = 8'(base + quo);
      end
    end
    res.in_range = (res.hue >= hue_lo) && (res.hue <= hue_hi) &&
                   (res.sat >= sat_lo) && (res.sat <= sat_hi) &&
                   (res.val >= val_lo) && (res.val <= val_hi);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // bounds, pixel beats and result beats, all sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    hsv_beat_t want;
    if (!rst_ni) begin
      hue_lo = HueLowRst;
      hue_hi = HueHighRst;
      sat_lo = SatLowRst;
      sat_hi = SatHighRst;
      val_lo = ValLowRst;
      val_hi = ValHighRst;
    end else begin
      // result beat against the oldest prediction
      if (done_i) begin
        if (hsv_expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no pixel pending (hue %0d sat %0d val %0d)",
                                    hue_i, saturation_i, brightness_i));
        end else begin
          want = hsv_expected_q.pop_front();
          if (in_range_i !== want.in_range)
            report_mismatch($sformatf("in_range got %b want %b (hue %0d sat %0d val %0d)",
                                      in_range_i, want.in_range, want.hue, want.sat, want.val));
          if (hue_i !== want.hue)
            report_mismatch($sformatf("hue got %0d want %0d", hue_i, want.hue));
          if (saturation_i !== want.sat)
            report_mismatch($sformatf("saturation got %0d want %0d", saturation_i, want.sat));
          if (brightness_i !== want.val)
            report_mismatch($sformatf("brightness got %0d want %0d", brightness_i, want.val));
        end
      end
      // pixel beat
      if (start_i && !busy_i) hsv_expected_q.push_back(hsv_of_pixel(pixel_rgb565_i));
      // register writes, unmapped indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegHueLow:  hue_lo = cfg_data_i;
          RegHueHigh: hue_hi = cfg_data_i;
          RegSatLow:  sat_lo = cfg_data_i;
          RegSatHigh: sat_hi = cfg_data_i;
          RegValLow:  val_lo = cfg_data_i;
          RegValHigh: val_hi = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = hsv_expected_q.size();
    end
  end

endmodule

### verif/tb_rgb565_hsv_color_threshold.sv
`timescale 1ns / 100ps

module tb_rgb565_hsv_color_threshold;
  import rhct_pkg::*;

  localparam int ResultLatency = 10;
  localparam int StallLimit    = 2000;
  localparam int PhaseBeats    = 275;

  // indexes past the last register, writes there must be ignored
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] pixel_rgb565;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [7:0]  cfg_data;
  logic        done;
  logic        in_range;
  logic [7:0]  hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  int pending;
  int fail_count;
  int gap_pct;
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  rgb565_hsv_color_threshold dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_rgb565_i (pixel_rgb565),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_o         (done),
    .in_range_o     (in_range),
    .hue_o          (hue),
    .saturation_o   (saturation),
    .brightness_o   (brightness)
  );

  hsv_threshold_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .pixel_rgb565_i (pixel_rgb565),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .done_i         (done),
    .in_range_i     (in_range),
    .hue_i          (hue),
    .saturation_i   (saturation),
    .brightness_i   (brightness),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // watchdog on cycles with no pixel beat and no result beat
  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [15:0] px);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      start        <= 1'b0;
      pixel_rgb565 <= 16'($urandom_range(0, 65535));
      @(negedge clk_i);
    end
    start        <= 1'b1;
    pixel_rgb565 <= px;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_window(input logic [7:0] hl, input logic [7:0] hh,
                            input logic [7:0] sl, input logic [7:0] sh,
                            input logic [7:0] vl, input logic [7:0] vh);
    write_reg(RegHueLow, hl);
    write_reg(RegHueHigh, hh);
    write_reg(RegSatLow, sl);
    write_reg(RegSatHigh, sh);
    write_reg(RegValLow, vl);
    write_reg(RegValHigh, vh);
  endtask

  // ordered bounds most of the time, an empty window now and then
  task automatic random_window();
    logic [7:0] lo [3];
    logic [7:0] hi [3];
    logic [7:0] a, b;
    for (int k = 0; k < 3; k++) begin
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if ((a > b) == ($urandom_range(0, 9) != 0)) begin
        lo[k] = b;
        hi[k] = a;
      end else begin
        lo[k] = a;
        hi[k] = b;
      end
    end
    set_window(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  // random pixel, biased toward channel ties and greys
  function automatic logic [15:0] pick_pixel();
    logic [4:0] r5, b5;
    logic [5:0] g6;
    r5 = 5'($urandom_range(0, 31));
    g6 = 6'($urandom_range(0, 63));
    b5 = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0: g6 = {r5, 1'b0};
      1: g6 = {b5, 1'b0};
      2: b5 = r5;
      3: begin
        g6 = {r5, 1'b0};
        b5 = r5;
      end
      default: ;
    endcase
    return {r5, g6, b5};
  endfunction

  initial begin
    start        = 1'b0;
    pixel_rgb565 = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    gap_pct      = 12;
    rst_ni       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pixels under the reset bounds
    send_pixel(16'h0000);  // black
    send_pixel(16'hFFFF);  // white, green just ahead
    send_pixel(16'hF800);  // pure red
    send_pixel(16'h07E0);  // pure green
    send_pixel(16'h001F);  // pure blue
    send_pixel(16'h8410);  // mid grey
    send_pixel(16'hFFDF);  // bright grey
    send_pixel(16'hA500);  // red ties green
    send_pixel(16'h0514);  // green ties blue
    send_pixel(16'hA014);  // red ties blue
    send_pixel(16'hF80A);  // red ahead, hue wraps below zero
    send_pixel(16'hF81F);  // magenta, red wins the tie
    send_pixel(16'h501F);  // blue ahead with red over green
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h0001);  // smallest blue
    send_pixel(16'h0020);  // smallest green
    send_pixel(16'h0800);  // smallest red

    // random phases, each under its own window
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: set_window(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        1: begin
          set_window(8'd200, 8'd100, 8'd0, 8'd255, 8'd0, 8'd255);
          write_reg(RegSpareLo, 8'($urandom_range(0, 255)));
          write_reg(RegSpareHi, 8'($urandom_range(0, 255)));
        end
        2: set_window(8'd85, 8'd85, 8'd255, 8'd255, 8'd0, 8'd255);
        default: random_window();
      endcase
      gap_pct = (ph < 2) ? 12 : ((ph < 4) ? 80 : 0);
      for (int n = 0; n < PhaseBeats; n++) begin
        // let the pipe run dry once mid phase
        if (ph == 3 && n == PhaseBeats / 2) drain_results();
        send_pixel(pick_pixel());
      end
    end

    drain_results();
    repeat (ResultLatency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
